FILE: rtl/core/tnon_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_pkg
// Shared constants and types of the telnet option negotiator: telnet command
// codes, the output beat record and the sizing of the output beat queue.
// ----------------------------------------------------------------------------
package tnon_pkg;

  // Telnet command codes.
  localparam logic [7:0] TnIac  = 8'hFF;
  localparam logic [7:0] TnWill = 8'hFB;
  localparam logic [7:0] TnWont = 8'hFC;
  localparam logic [7:0] TnDo   = 8'hFD;
  localparam logic [7:0] TnDont = 8'hFE;
  localparam logic [7:0] TnSb   = 8'hFA;
  localparam logic [7:0] TnSe   = 8'hF0;

  // Option agreed to after reset.
  localparam logic [7:0] AgreedOptionRst = 8'h01;

  // Beat kinds.
  localparam logic KindData  = 1'b0;
  localparam logic KindReply = 1'b1;

  // Largest number of beats one received byte can cause.
  localparam int unsigned MaxBeats = 3;
  localparam int unsigned NumW     = $clog2(MaxBeats + 1);

  // Output beat queue sizing.
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // One output beat.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } beat_t;

  // Beats caused by one received byte; only the first num entries count.
  typedef struct packed {
    logic [NumW-1:0]            num;
    beat_t [MaxBeats-1:0]       beat;
  } parse_res_t;

endpackage

FILE: rtl/core/tnon_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_parse
// Receive-side telnet parser. Holds the parse state, the pending command and
// the agreed option, and works out the beats that one received byte causes.
// ----------------------------------------------------------------------------
module tnon_parse
  import tnon_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output parse_res_t res_o
);

  typedef enum logic [2:0] {
    StData   = 3'd0,
    StIac    = 3'd1,
    StCmd    = 3'd2,
    StSb     = 3'd3,
    StSbData = 3'd4,
    StSbIac  = 3'd5
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] pend_q, pend_d;
  logic [7:0] agreed_q;
  logic [7:0] answer;
  logic       answer_ok;

  // Answer to a pending negotiation command.
  always_comb begin
    answer    = TnWont;
    answer_ok = 1'b1;
    case (pend_q)
      TnDo:    answer = (byte_i == agreed_q) ? TnWill : TnWont;
      TnWill:  answer = TnDo;
      TnDont:  answer = TnWont;
      TnWont:  answer = TnDont;
      default: answer_ok = 1'b0;
    endcase
  end

  // Next state and the beats caused by the current byte.
  always_comb begin
    state_d = StData;
    pend_d  = pend_q;
    res_o   = '0;
    res_o.beat[0] = '{kind: KindData, data: byte_i, last: 1'b1};
    case (state_q)
      StIac: begin
        if (byte_i inside {TnWill, TnWont, TnDo, TnDont}) begin
          pend_d  = byte_i;
          state_d = StCmd;
        end else if (byte_i == TnSb) begin
          state_d = StSb;
        end else if (byte_i == TnIac) begin
          res_o.num = NumW'(1);
        end
      end
      StCmd: begin
        if (answer_ok) begin
          res_o.num     = NumW'(MaxBeats);
          res_o.beat[0] = '{kind: KindReply, data: TnIac, last: 1'b0};
          res_o.beat[1] = '{kind: KindReply, data: answer, last: 1'b0};
          res_o.beat[2] = '{kind: KindReply, data: byte_i, last: 1'b1};
        end
      end
      StSb: begin
        state_d = StSbData;
      end
      StSbData: begin
        state_d = (byte_i == TnIac) ? StSbIac : StSbData;
      end
      StSbIac: begin
        state_d = (byte_i == TnIac) ? StSbData : StData;
      end
      default: begin
        if (byte_i == TnIac) begin
          state_d = StIac;
        end else begin
          res_o.num = NumW'(1);
        end
      end
    endcase
  end

  // Parse state, pending command and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StData;
      pend_q   <= '0;
      agreed_q <= AgreedOptionRst;
    end else begin
      if (accept_i) begin
        state_q <= state_d;
        pend_q  <= pend_d;
      end
      if (cfg_we_i) begin
        agreed_q <= cfg_wdata_i;
      end
    end
  end

endmodule

FILE: rtl/core/tnon_beat_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnon_beat_fifo
// Output beat queue. Takes up to three beats in one cycle and hands out one
// beat per cycle while ready_i is high, on a valid/ready channel.
// ----------------------------------------------------------------------------
module tnon_beat_fifo
  import tnon_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  parse_res_t push_i,
  input  logic       push_en_i,
  output logic       room_o,
  output logic       valid_o,
  input  logic       ready_i,
  output beat_t      beat_o
);

  beat_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic [NumW-1:0]   push_num;
  logic              pop;

  assign push_num = push_en_i ? push_i.num : '0;
  assign pop      = valid_o && ready_i;
  assign valid_o  = (cnt_q != '0);
  assign beat_o   = mem_q[rd_ptr_q];
  // Room for a full reply burst.
  assign room_o   = (cnt_q <= QCntW'(QDepth - MaxBeats));

  // Beat storage.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxBeats; k++) begin
      if (NumW'(k) < push_num) begin
        mem_q[wr_ptr_q + QPtrW'(k)] <= push_i.beat[k];
      end
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_num);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push_num) - QCntW'(pop);
    end
  end

endmodule

FILE: rtl/core/telnet_option_negotiator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiator_core
// Telnet receive parser: passes data bytes through, answers option
// negotiation with IAC/answer/option reply beats and skips subnegotiation.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  in        in_valid_i in_ready_o in_byte_i  received byte, one per beat
//  out       out_valid_o out_ready_i          out_kind_o out_byte_o out_last_o
//  cfg       cfg_we_i cfg_wdata_i             agreed option, written at once
//
// A byte is parsed in the cycle it is accepted; its beats land in an
// eight-entry queue and can leave from the next cycle on, one per ready cycle.
// Input is taken every cycle while the queue has room for three beats, so
// the sustained rate is one byte per cycle with the output ready.
// Reset puts the parser in the data state and the agreed option at 1.
// An output stall only holds off input once the queue nears full.
// ----------------------------------------------------------------------------
module telnet_option_negotiator_core
  import tnon_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  parse_res_t res;
  beat_t      beat;
  logic       room;
  logic       accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  // Byte parser.
  tnon_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .byte_i      (in_byte_i),
    .res_o       (res)
  );

  // Output beat queue.
  tnon_beat_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res),
    .push_en_i (accept),
    .room_o    (room),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .beat_o    (beat)
  );

  assign out_kind_o = beat.kind;
  assign out_byte_o = beat.data;
  assign out_last_o = beat.last;

endmodule

FILE: tb/telnet_option_negotiator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiator_core_tb
// Self-checking bench for the telnet receive parser. A queue of received
// bytes feeds a valid/ready driver, and a clocked monitor runs a parser model
// on every accepted byte. Each output beat is checked in order against the
// predicted data and reply beats. The agreed option is changed between phases
// while the block is idle, and both sides insert random gaps.
// ----------------------------------------------------------------------------
module telnet_option_negotiator_core_tb;
  import tnon_pkg::*;

  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned ResetCycles  = 5;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned PhaseBytes   = 60;

  // Parser states of the model.
  typedef enum logic [2:0] {
    RxData,
    RxIac,
    RxCmd,
    RxSbOpt,
    RxSbBody,
    RxSbIac
  } rx_state_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       out_kind_o;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  // Byte stream waiting to be driven and beats waiting to come out.
  logic [7:0] rx_stream[$];
  beat_t      expected_beats[$];

  // Parser model state and its copy of the agreed option.
  rx_state_e  rx_state   = RxData;
  logic [7:0] pend_cmd   = 8'h00;
  logic [7:0] agreed_opt = AgreedOptionRst;

  // Handshake flags seen at the last rising edge.
  logic in_fire  = 1'b0;
  logic out_fire = 1'b0;

  int send_gap     = 0;
  int recv_gap     = 0;
  int send_gap_max = 0;
  int recv_gap_max = 0;

  int error_count   = 0;
  int bytes_sent    = 0;
  int beats_checked = 0;
  int reply_beats   = 0;
  int settings_used = 1;
  int idle_cycles   = 0;

  telnet_option_negotiator_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_kind_o (out_kind_o),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic void push_beat(input logic kind, input logic [7:0] data,
                                    input logic last);
    beat_t b;
    b.kind = kind;
    b.data = data;
    b.last = last;
    expected_beats.push_back(b);
  endfunction

  // Advance the parser model by one received byte and queue its beats.
  function automatic void predict_rx_byte(input logic [7:0] rx);
    logic [7:0] answer;
    logic       known;
    answer = TnDont;
    known  = 1'b1;
    case (rx_state)
      RxIac: begin
        if (rx == TnWill || rx == TnWont || rx == TnDo || rx == TnDont) begin
          pend_cmd = rx;
          rx_state = RxCmd;
        end else if (rx == TnSb) begin
          rx_state = RxSbOpt;
        end else begin
          rx_state = RxData;
          if (rx == TnIac) push_beat(KindData, TnIac, 1'b1);
        end
      end
      RxCmd: begin
        rx_state = RxData;
        case (pend_cmd)
          TnDo:    answer = (rx == agreed_opt) ? TnWill : TnWont;
          TnWill:  answer = TnDo;
          TnDont:  answer = TnWont;
          TnWont:  answer = TnDont;
          default: known = 1'b0;
        endcase
        if (known) begin
          push_beat(KindReply, TnIac, 1'b0);
          push_beat(KindReply, answer, 1'b0);
          push_beat(KindReply, rx, 1'b1);
        end
      end
      // The option byte of a subnegotiation is taken whatever it is.
      RxSbOpt: rx_state = RxSbBody;
      RxSbBody: begin
        if (rx == TnIac) rx_state = RxSbIac;
      end
      RxSbIac: rx_state = (rx == TnIac) ? RxSbBody : RxData;
      default: begin
        if (rx == TnIac) begin
          rx_state = RxIac;
        end else begin
          rx_state = RxData;
          push_beat(KindData, rx, 1'b1);
        end
      end
    endcase
  endfunction

  // Input driver: a new byte after the previous beat is taken and a gap.
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (rx_stream.size() != 0) begin
        in_valid_i <= 1'b1;
        in_byte_i  <= rx_stream.pop_front();
        send_gap   <= $urandom_range(0, send_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: a random stall after every beat taken.
  always @(negedge clk_i) begin
    int stall;
    stall = 0;
    if (out_fire) begin
      stall = $urandom_range(0, recv_gap_max);
      out_ready_i <= (stall == 0);
      recv_gap    <= (stall > 0) ? stall - 1 : 0;
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap    <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predict on every accepted byte, check every output beat.
  always @(posedge clk_i) begin
    beat_t want;
    in_fire  <= in_valid_i && in_ready_o;
    out_fire <= out_valid_o && out_ready_i;
    if (in_valid_i && in_ready_o) begin
      predict_rx_byte(in_byte_i);
      bytes_sent = bytes_sent + 1;
    end
    if (out_valid_o && out_ready_i) begin
      beats_checked = beats_checked + 1;
      if (out_kind_o == KindReply) reply_beats = reply_beats + 1;
      if (expected_beats.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= MaxReports)
          $display("%0t: unexpected beat kind=%0b byte=%02h last=%0b",
                   $realtime, out_kind_o, out_byte_o, out_last_o);
      end else begin
        want = expected_beats.pop_front();
        if (out_kind_o !== want.kind || out_byte_o !== want.data ||
            out_last_o !== want.last) begin
          error_count = error_count + 1;
          if (error_count <= MaxReports)
            $display("%0t: beat mismatch: expected kind=%0b byte=%02h last=%0b",
                     $realtime, want.kind, want.data, want.last,
                     ", got kind=%0b byte=%02h last=%0b",
                     out_kind_o, out_byte_o, out_last_o);
        end
      end
    end
    // Watchdog on cycles with no beat moving on either channel.
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Wait until all bytes are taken and all beats have come out.
  task automatic wait_idle();
    do @(posedge clk_i);
    while (rx_stream.size() != 0 || in_valid_i || expected_beats.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_agreed(input logic [7:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    agreed_opt  = value;
    settings_used = settings_used + 1;
  endtask

  // Subnegotiation with random body, closed by IAC SE or abandoned.
  task automatic add_subneg(input bit abandon);
    int         len;
    logic [7:0] b;
    len = $urandom_range(0, 6);
    rx_stream.push_back(TnIac);
    rx_stream.push_back(TnSb);
    rx_stream.push_back(8'($urandom_range(0, 255)));
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      rx_stream.push_back(b);
      if (b == TnIac) rx_stream.push_back(TnIac);
    end
    rx_stream.push_back(TnIac);
    rx_stream.push_back(abandon ? 8'($urandom_range(0, 254)) : TnSe);
  endtask

  // Mostly well-formed sequences with random content, plus loose bytes.
  // The count is in bytes queued, whatever sequences they form.
  task automatic add_random_bytes(input int count);
    int         sent;
    int         start;
    int         pick;
    logic [7:0] cmd;
    sent  = 0;
    start = rx_stream.size();
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        rx_stream.push_back(8'($urandom_range(0, 254)));
      end else if (pick < 38) begin
        rx_stream.push_back(TnIac);
        rx_stream.push_back(TnIac);
      end else if (pick < 68) begin
        case ($urandom_range(0, 3))
          0:       cmd = TnWill;
          1:       cmd = TnWont;
          2:       cmd = TnDo;
          default: cmd = TnDont;
        endcase
        rx_stream.push_back(TnIac);
        rx_stream.push_back(cmd);
        rx_stream.push_back($urandom_range(0, 1) ? agreed_opt
                                                 : 8'($urandom_range(0, 255)));
      end else if (pick < 78) begin
        add_subneg(1'b0);
      end else if (pick < 82) begin
        add_subneg(1'b1);
      end else if (pick < 88) begin
        // Stray or unknown command after IAC.
        rx_stream.push_back(TnIac);
        rx_stream.push_back($urandom_range(0, 1) ? TnSe
                                                 : 8'($urandom_range(0, 249)));
      end else begin
        rx_stream.push_back(8'($urandom_range(0, 255)));
      end
      sent = rx_stream.size() - start;
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    logic [7:0] opt_values[6];
    int         send_max[6];
    int         recv_max[6];

    // Data extremes, escaped IAC, every command, stray SE, a subnegotiation
    // whose option is IAC with an escaped IAC that is then abandoned.
    directed = '{8'h00, 8'hFE, TnIac, TnIac,
                 TnIac, TnDo, 8'h01, TnIac, TnWill, 8'h00,
                 TnIac, TnWont, 8'hFF, TnIac, TnDont, 8'h18,
                 TnIac, TnSe,
                 TnIac, TnSb, TnIac, TnIac, TnIac, TnIac, 8'h41};
    opt_values = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h80};
    opt_values[2] = 8'($urandom_range(0, 255));
    opt_values[4] = 8'($urandom_range(0, 255));
    send_max = '{8, 0, 8, 0, 8, 3};
    recv_max = '{8, 0, 0, 8, 8, 3};

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed bytes with the option left at its reset value.
    send_gap_max = 2;
    recv_gap_max = 2;
    foreach (directed[i]) rx_stream.push_back(directed[i]);
    wait_idle();

    // Random phases, one option setting each.
    for (int p = 0; p < 6; p++) begin
      write_agreed(opt_values[p]);
      send_gap_max = send_max[p];
      recv_gap_max = recv_max[p];
      add_random_bytes(PhaseBytes / 2);
      if (p == 2) wait_idle();
      add_random_bytes(PhaseBytes / 2);
      wait_idle();
    end

    // Beats still owed at the end are failures.
    if (expected_beats.size() != 0) begin
      error_count = error_count + expected_beats.size();
      $display("%0d expected beats never came out", expected_beats.size());
    end

    $display("Drove %0d bytes under %0d agreed option settings.",
             bytes_sent, settings_used);
    $display("Checked %0d output beats, %0d of them negotiation replies; %0d errors.",
             beats_checked, reply_beats, error_count);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
